>>> rtl/bce_pkg.sv
// Shared types and constants for the battery charge estimator.
// No dependencies; used by every module of the block.
package bce_pkg;

  localparam int MAX_CURVES = 8;
  localparam int MAX_COEFFS = 8;
  localparam int CURVE_W    = $clog2(MAX_CURVES);
  localparam int COEFF_W    = $clog2(MAX_COEFFS);
  localparam int CNT_W      = $clog2(MAX_COEFFS + 1);
  localparam int NCURVE_W   = $clog2(MAX_CURVES + 1);

  // divider: 24-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int DVD_W     = 24;
  localparam int DVS_W     = 16;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // table word codes of a load transfer
  localparam logic [3:0] WORD_TEMP   = 4'd0;
  localparam logic [3:0] WORD_MINV   = 4'd1;
  localparam logic [3:0] WORD_STEP   = 4'd2;
  localparam logic [3:0] WORD_MAXX   = 4'd3;
  localparam logic [3:0] WORD_COUNT  = 4'd4;
  localparam logic [3:0] WORD_SCALER = 4'd5;
  localparam logic [3:0] WORD_COEF0  = 4'd6;

  localparam logic [6:0] PCT_FULL = 7'd100;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAPTURE,
    OP_SEARCH,
    OP_XSTART,
    OP_XCHECK,
    OP_READ,
    OP_MULLO,
    OP_MULHI,
    OP_SCALE1,
    OP_SCALE2,
    OP_SCALE3,
    OP_INTERP,
    OP_IDIVSTART,
    OP_FINISH,
    OP_OUTPUT
  } op_t;

  typedef struct packed {
    logic search_more;
    logic x_nonpos;
    logic x_skip;
    logic cnt_zero;
    logic k_one;
    logic side;
    logic div_done;
    logic span_zero;
  } stat_t;

endpackage

>>> rtl/bce_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bce_pkg for widths.
module bce_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bce_pkg::DVD_W-1:0]   dividend,
  input  logic [bce_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [bce_pkg::DVD_W-1:0]   quotient
);

  logic                            busy;
  logic [bce_pkg::DIV_CNT_W-1:0]   cnt;
  logic [bce_pkg::DVS_W-1:0]       rem;
  logic [bce_pkg::DVS_W-1:0]       dvs;
  logic [bce_pkg::DVS_W:0]         rem_sh;
  logic [bce_pkg::DVS_W:0]         rem_sub;
  logic                            ge;

  assign rem_sh  = {rem, quotient[bce_pkg::DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign done    = busy && (cnt == bce_pkg::DIV_CNT_W'(bce_pkg::DVD_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[bce_pkg::DVD_W-2:0], ge};
      rem      <= ge ? rem_sub[bce_pkg::DVS_W-1:0] : rem_sh[bce_pkg::DVS_W-1:0];
    end
  end

endmodule

>>> rtl/bce_dp.sv
// Datapath: curve table, coefficient memory, Horner multiply, scaling and
// temperature interpolation. Depends on bce_pkg and bce_div.
module bce_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_data,
  input  bce_pkg::op_t          op,
  input  logic [15:0]           voltage_mv,
  input  logic signed [15:0]    temperature_dc,
  input  logic [2:0]            load_curve,
  input  logic [3:0]            load_word,
  input  logic signed [63:0]    load_value,
  output bce_pkg::stat_t        stat,
  output logic [6:0]            state_of_charge
);

  localparam int CW    = bce_pkg::CURVE_W;
  localparam int NCW_T = bce_pkg::NCURVE_W + 1;

  logic [3:0] curves_in_use;

  // curve table, undefined until loaded
  logic signed [15:0] ct    [bce_pkg::MAX_CURVES];
  logic [15:0]        cmin  [bce_pkg::MAX_CURVES];
  logic [15:0]        cstep [bce_pkg::MAX_CURVES];
  logic [15:0]        cmax  [bce_pkg::MAX_CURVES];
  logic [3:0]         ccnt  [bce_pkg::MAX_CURVES];
  logic [5:0]         csh   [bce_pkg::MAX_CURVES];
  logic [63:0]        cmem  [bce_pkg::MAX_CURVES * bce_pkg::MAX_COEFFS];
  logic [63:0]        rdata;

  logic [15:0]        v;
  logic signed [15:0] t;
  logic [CW-1:0]      blim;
  logic [CW-1:0]      b;
  logic               side;
  logic [15:0]        x;
  logic [bce_pkg::CNT_W-1:0] k;
  logic [63:0]        y;
  logic [63:0]        acc;
  logic [6:0]         left;
  logic [6:0]         right;
  logic signed [16:0] span;
  logic signed [24:0] num;
  logic               neg;
  logic [6:0]         soc;

  logic [CW-1:0]      b1;
  logic [CW-1:0]      cur;
  logic [16:0]        diff;
  logic [15:0]        step_eff;
  logic [15:0]        x_q;
  logic [bce_pkg::CNT_W-1:0] cnt_eff;
  logic [bce_pkg::CNT_W-1:0] k_m1;
  logic [5:0]         sh;
  logic [5:0]         sh_m1;
  logic [63:0]        y_sc3;
  logic [6:0]         pct3;
  logic               wr_pct;
  logic [6:0]         pct_val;
  logic [47:0]        plo;
  logic [47:0]        phi;
  logic signed [7:0]  dl;
  logic signed [16:0] dt;
  logic [24:0]        num_abs;
  logic [16:0]        span_abs;
  logic [bce_pkg::DVD_W-1:0] div_dvd;
  logic [bce_pkg::DVS_W-1:0] div_dvs;
  logic               div_start;
  logic               div_done;
  logic [bce_pkg::DVD_W-1:0] div_q;
  logic signed [25:0] q_s;
  logic signed [25:0] sum;
  logic [NCW_T-1:0]   n_eff;
  logic [bce_pkg::COEFF_W-1:0] load_coef;

  assign b1  = b + 1'b1;
  assign cur = side ? b1 : b;

  // effective curve count, clamped to 2..MAX_CURVES
  always_comb begin
    if (curves_in_use < 4'd2) begin
      n_eff = NCW_T'(2);
    end else if ({{(NCW_T > 4 ? NCW_T - 4 : 0){1'b0}}, curves_in_use} >
                 NCW_T'(bce_pkg::MAX_CURVES)) begin
      n_eff = NCW_T'(bce_pkg::MAX_CURVES);
    end else begin
      n_eff = NCW_T'(curves_in_use);
    end
  end

  assign diff     = {1'b0, v} - {1'b0, cmin[cur]};
  assign step_eff = (cstep[cur] == 16'd0) ? 16'd1 : cstep[cur];
  assign x_q      = div_q[15:0];
  assign cnt_eff  = (ccnt[cur] > 4'(bce_pkg::MAX_COEFFS)) ?
                    bce_pkg::CNT_W'(bce_pkg::MAX_COEFFS) : bce_pkg::CNT_W'(ccnt[cur]);
  assign k_m1     = k - 1'b1;
  assign sh       = csh[cur];
  assign sh_m1    = sh - 6'd1;
  assign plo      = y[31:0] * x;
  assign phi      = y[63:32] * x;
  assign load_coef = bce_pkg::COEFF_W'(load_word - bce_pkg::WORD_COEF0);

  always_comb begin
    y_sc3 = (sh != 6'd0) ? $unsigned($signed(y) >>> 1) : y;
    if (y_sc3[63]) begin
      pct3 = 7'd0;
    end else if (y_sc3 > 64'(bce_pkg::PCT_FULL)) begin
      pct3 = bce_pkg::PCT_FULL;
    end else begin
      pct3 = y_sc3[6:0];
    end
  end

  assign stat.search_more = (b < blim) && !(ct[b1] > t);
  assign stat.x_nonpos    = diff[16] || (diff == 17'd0);
  assign stat.x_skip      = (x_q == 16'd0) || (x_q >= cmax[cur]);
  assign stat.cnt_zero    = (cnt_eff == '0);
  assign stat.k_one       = (k == bce_pkg::CNT_W'(1));
  assign stat.side        = side;
  assign stat.div_done    = div_done;
  assign stat.span_zero   = (ct[b] == ct[b1]);

  always_comb begin
    wr_pct  = 1'b0;
    pct_val = 7'd0;
    unique case (op)
      bce_pkg::OP_XSTART: begin
        wr_pct = stat.x_nonpos;
      end
      bce_pkg::OP_XCHECK: begin
        wr_pct  = stat.x_skip;
        pct_val = (x_q == 16'd0) ? 7'd0 : bce_pkg::PCT_FULL;
      end
      bce_pkg::OP_SCALE3: begin
        wr_pct  = 1'b1;
        pct_val = pct3;
      end
      default: begin
      end
    endcase
  end

  // interpolation operands
  assign dl       = $signed({1'b0, right}) - $signed({1'b0, left});
  assign dt       = $signed({t[15], t}) - $signed({ct[b][15], ct[b]});
  assign num_abs  = num[24] ? 25'(-num) : 25'(num);
  assign span_abs = span[16] ? 17'(-span) : 17'(span);

  assign div_start = (op == bce_pkg::OP_IDIVSTART) ||
                     ((op == bce_pkg::OP_XSTART) && !stat.x_nonpos);
  assign div_dvd   = (op == bce_pkg::OP_IDIVSTART) ? num_abs[bce_pkg::DVD_W-1:0] :
                     bce_pkg::DVD_W'(diff[15:0]);
  assign div_dvs   = (op == bce_pkg::OP_IDIVSTART) ? span_abs[bce_pkg::DVS_W-1:0] : step_eff;

  bce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_s = neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign sum = $signed({19'd0, left}) + q_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      curves_in_use <= 4'd2;
    end else if (cfg_we) begin
      curves_in_use <= cfg_data;
    end
  end

  // table and coefficient writes from load transfers
  always_ff @(posedge clk) begin
    if (op == bce_pkg::OP_LOAD) begin
      unique case (load_word)
        bce_pkg::WORD_TEMP:   ct[load_curve]    <= load_value[15:0];
        bce_pkg::WORD_MINV:   cmin[load_curve]  <= load_value[15:0];
        bce_pkg::WORD_STEP:   cstep[load_curve] <= load_value[15:0];
        bce_pkg::WORD_MAXX:   cmax[load_curve]  <= load_value[15:0];
        bce_pkg::WORD_COUNT:  ccnt[load_curve]  <= load_value[3:0];
        bce_pkg::WORD_SCALER: csh[load_curve]   <= load_value[5:0];
        default: begin
          if (load_word >= bce_pkg::WORD_COEF0 &&
              (load_word - bce_pkg::WORD_COEF0) < 4'(bce_pkg::MAX_COEFFS)) begin
            cmem[{load_curve, load_coef}] <= load_value;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == bce_pkg::OP_READ) begin
      rdata <= cmem[{cur, k_m1[bce_pkg::COEFF_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pct) begin
      if (side) begin
        right <= pct_val;
      end else begin
        left <= pct_val;
      end
    end
    unique case (op)
      bce_pkg::OP_CAPTURE: begin
        v    <= voltage_mv;
        t    <= temperature_dc;
        blim <= CW'(n_eff - NCW_T'(2));
        b    <= '0;
      end
      bce_pkg::OP_SEARCH: begin
        if (stat.search_more) begin
          b <= b1;
        end
      end
      bce_pkg::OP_XCHECK: begin
        x <= x_q;
        y <= '0;
        k <= cnt_eff;
      end
      bce_pkg::OP_MULLO: begin
        acc <= rdata + {16'd0, plo};
      end
      bce_pkg::OP_MULHI: begin
        y <= acc + {phi[31:0], 32'd0};
        k <= k_m1;
      end
      bce_pkg::OP_SCALE1: begin
        // times 100 = 64 + 32 + 4
        y <= (y << 6) + (y << 5) + (y << 2);
      end
      bce_pkg::OP_SCALE2: begin
        if (sh != 6'd0) begin
          y <= $unsigned($signed(y) >>> sh_m1) + 64'd1;
        end
      end
      bce_pkg::OP_INTERP: begin
        span <= $signed({ct[b1][15], ct[b1]}) - $signed({ct[b][15], ct[b]});
        num  <= 25'(dl * dt);
      end
      bce_pkg::OP_IDIVSTART: begin
        neg <= num[24] ^ span[16];
      end
      bce_pkg::OP_FINISH: begin
        if (span == 17'sd0) begin
          soc <= left;
        end else if (sum < 26'sd0) begin
          soc <= 7'd0;
        end else if (sum > 26'sd100) begin
          soc <= bce_pkg::PCT_FULL;
        end else begin
          soc <= sum[6:0];
        end
      end
      bce_pkg::OP_OUTPUT: begin
        state_of_charge <= soc;
      end
      default: begin
      end
    endcase
  end

  // side flips after each curve percentage; cleared at capture
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= 1'b0;
    end else if (op == bce_pkg::OP_CAPTURE) begin
      side <= 1'b0;
    end else if (wr_pct) begin
      side <= ~side;
    end
  end

endmodule

>>> rtl/bce_ctrl.sv
// Controller state machine: sequences search, per-curve evaluation and
// interpolation, and owns both handshakes. Depends on bce_pkg.
module bce_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           action,
  output logic           out_valid,
  input  logic           out_stall,
  input  bce_pkg::stat_t stat,
  output bce_pkg::op_t   op
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_SEARCH = 15'h0002,
    S_CX     = 15'h0004,
    S_XDIV   = 15'h0008,
    S_XCHK   = 15'h0010,
    S_HRD    = 15'h0020,
    S_HLO    = 15'h0040,
    S_HHI    = 15'h0080,
    S_SC1    = 15'h0100,
    S_SC2    = 15'h0200,
    S_SC3    = 15'h0400,
    S_INTERP = 15'h0800,
    S_IDS    = 15'h1000,
    S_IDIV   = 15'h2000,
    S_DONE   = 15'h4000
  } state_t;

  state_t state;
  state_t state_next;
  logic   fin;
  logic   fin_next;
  logic   out_load;
  state_t after_curve;

  assign in_stall    = (state != S_IDLE);
  assign after_curve = stat.side ? S_INTERP : S_CX;
  assign out_load    = (state == S_DONE) && !fin && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    fin_next   = 1'b0;
    op         = bce_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action) begin
            op         = bce_pkg::OP_CAPTURE;
            state_next = S_SEARCH;
          end else begin
            op = bce_pkg::OP_LOAD;
          end
        end
      end
      S_SEARCH: begin
        op = bce_pkg::OP_SEARCH;
        if (!stat.search_more) begin
          state_next = S_CX;
        end
      end
      S_CX: begin
        op         = bce_pkg::OP_XSTART;
        state_next = stat.x_nonpos ? after_curve : S_XDIV;
      end
      S_XDIV: begin
        if (stat.div_done) begin
          state_next = S_XCHK;
        end
      end
      S_XCHK: begin
        op = bce_pkg::OP_XCHECK;
        if (stat.x_skip) begin
          state_next = after_curve;
        end else begin
          state_next = stat.cnt_zero ? S_SC1 : S_HRD;
        end
      end
      S_HRD: begin
        op         = bce_pkg::OP_READ;
        state_next = S_HLO;
      end
      S_HLO: begin
        op         = bce_pkg::OP_MULLO;
        state_next = S_HHI;
      end
      S_HHI: begin
        op         = bce_pkg::OP_MULHI;
        state_next = stat.k_one ? S_SC1 : S_HRD;
      end
      S_SC1: begin
        op         = bce_pkg::OP_SCALE1;
        state_next = S_SC2;
      end
      S_SC2: begin
        op         = bce_pkg::OP_SCALE2;
        state_next = S_SC3;
      end
      S_SC3: begin
        op         = bce_pkg::OP_SCALE3;
        state_next = after_curve;
      end
      S_INTERP: begin
        op = bce_pkg::OP_INTERP;
        if (stat.span_zero) begin
          state_next = S_DONE;
          fin_next   = 1'b1;
        end else begin
          state_next = S_IDS;
        end
      end
      S_IDS: begin
        op         = bce_pkg::OP_IDIVSTART;
        state_next = S_IDIV;
      end
      S_IDIV: begin
        if (stat.div_done) begin
          state_next = S_DONE;
          fin_next   = 1'b1;
        end
      end
      S_DONE: begin
        // first cycle here computes the result, later cycles wait for the
        // output register
        if (fin) begin
          op = bce_pkg::OP_FINISH;
        end else if (out_load) begin
          op         = bce_pkg::OP_OUTPUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/battery_charge_estimator_top.sv
// Measure: the time from transfer to result is set by the search, per curve
// the shared divider plus the 32x16 multiplier for each coefficient, then
// the interpolation divide. Load transfers are taken back to back while idle.
// One item is in work at a time.
// Reset (rst, synchronous) clears control and sets curves_in_use to 2; the
// curve table and coefficients are undefined until loaded.
module battery_charge_estimator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [15:0]        voltage_mv,
  input  logic signed [15:0] temperature_dc,
  input  logic [2:0]         load_curve,
  input  logic [3:0]         load_word,
  input  logic signed [63:0] load_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         state_of_charge
);

  bce_pkg::op_t   op;
  bce_pkg::stat_t stat;

  bce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .op        (op)
  );

  bce_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .op              (op),
    .voltage_mv      (voltage_mv),
    .temperature_dc  (temperature_dc),
    .load_curve      (load_curve),
    .load_word       (load_word),
    .load_value      (load_value),
    .stat            (stat),
    .state_of_charge (state_of_charge)
  );

  a_measure_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action) |=> in_stall)
    else $error("measure transfer did not close the input");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !action && !out_valid) |=> !out_valid)
    else $error("load transfer produced a result");

  a_soc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state_of_charge <= 7'd100))
    else $error("state of charge above 100");

endmodule
